// ===== src/lrupr_pkg.sv =====
// Shared constants, types and state codes of the LRU page replacement block.
`timescale 1ns / 1ps

package lrupr_pkg;

   localparam int FRAME_COUNT = 16;
   localparam int PAGE_BITS   = 16;
   localparam int FRAME_W     = $clog2(FRAME_COUNT);
   localparam int RANK_W      = FRAME_W;
   localparam int CNT_W       = $clog2(FRAME_COUNT + 1);
   localparam int CFG_W       = 5;
   localparam int FAULT_W     = 16;

   localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_LAST,
      ST_UPDATE
   } state_type;

   typedef struct packed {
      logic                 found;
      logic [FRAME_W-1:0]   match_idx;
      logic [RANK_W-1:0]    match_rank;
      logic                 empty_found;
      logic [FRAME_W-1:0]   empty_idx;
      logic [CNT_W-1:0]     valid_count;
      logic [FRAME_W-1:0]   vict_idx;
      logic [RANK_W-1:0]    vict_rank;
      logic [PAGE_BITS-1:0] vict_tag;
   } scan_type;

   typedef struct packed {
      logic               en;
      logic               fill;
      logic [FRAME_W-1:0] frame;
      logic [RANK_W-1:0]  old_rank;
   } touch_type;

endpackage

// ===== src/lrupr_tag_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module lrupr_tag_ram #(
   parameter  int DEPTH = 16,
   parameter  int WIDTH = 16,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/lrupr_rank_table.sv =====
// Frame valid bits and recency ranks with the registered recency update.
`timescale 1ns / 1ps

module lrupr_rank_table (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [lrupr_pkg::CNT_W-1:0]   n_active,
   input  logic [lrupr_pkg::FRAME_W-1:0] rd_idx,
   input  lrupr_pkg::touch_type          touch,
   output logic                          rd_valid,
   output logic [lrupr_pkg::RANK_W-1:0]  rd_rank
);
   import lrupr_pkg::*;

   logic              valid_ff [FRAME_COUNT];
   logic              valid_in [FRAME_COUNT];
   logic [RANK_W-1:0] rank_ff  [FRAME_COUNT];
   logic [RANK_W-1:0] rank_in  [FRAME_COUNT];

   always_comb begin
      for (int i = 0; i < FRAME_COUNT; i++) begin
         valid_in[i] = valid_ff[i];
         rank_in[i]  = rank_ff[i];
         if (touch.en) begin
            if (FRAME_W'(i) == touch.frame) begin
               rank_in[i] = '0;
               if (touch.fill) begin
                  valid_in[i] = 1'b1;
               end
            end else if ((CNT_W'(i) < n_active) && valid_ff[i] &&
                         (rank_ff[i] < touch.old_rank)) begin
               rank_in[i] = rank_ff[i] + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < FRAME_COUNT; i++) begin
            valid_ff[i] <= 1'b0;
            rank_ff[i]  <= '0;
         end
      end else begin
         for (int i = 0; i < FRAME_COUNT; i++) begin
            valid_ff[i] <= valid_in[i];
            rank_ff[i]  <= rank_in[i];
         end
      end
   end

   assign rd_valid = valid_ff[rd_idx];
   assign rd_rank  = rank_ff[rd_idx];

endmodule

// ===== src/lrupr_scan.sv =====
// Scan accumulator: match, first empty frame, valid count and oldest frame.
`timescale 1ns / 1ps

module lrupr_scan (
   input  logic                            clock,
   input  logic                            clear,
   input  logic                            data_en,
   input  logic [lrupr_pkg::FRAME_W-1:0]   data_idx,
   input  logic [lrupr_pkg::PAGE_BITS-1:0] tag,
   input  logic                            frame_valid,
   input  logic [lrupr_pkg::RANK_W-1:0]    rank,
   input  logic [lrupr_pkg::PAGE_BITS-1:0] page,
   output lrupr_pkg::scan_type             result
);
   import lrupr_pkg::*;

   scan_type result_ff;
   scan_type result_in;

   always_comb begin
      result_in = result_ff;
      if (clear) begin
         result_in = '0;
      end else if (data_en) begin
         if (frame_valid) begin
            result_in.valid_count = result_ff.valid_count + 1'b1;
            if (!result_ff.found && (tag == page)) begin
               result_in.found      = 1'b1;
               result_in.match_idx  = data_idx;
               result_in.match_rank = rank;
            end
         end else if (!result_ff.empty_found) begin
            result_in.empty_found = 1'b1;
            result_in.empty_idx   = data_idx;
         end
         if ((data_idx == '0) || (rank > result_ff.vict_rank)) begin
            result_in.vict_idx  = data_idx;
            result_in.vict_rank = rank;
            result_in.vict_tag  = tag;
         end
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule

// ===== src/lru_page_replacement.sv =====
// Top level of the LRU page replacement block: sequencer, config and result register.
//
// Usage:
//   req_*  : one page reference per transaction (req_page), valid/ready.
//   rsp_*  : one result per reference: hit, frame used, evicted page, fault count.
//   csr_*  : write of frames_in_use (csr_data); taken only while no reference
//            is in progress.
// Sequence: a taken request scans the active frames, reading the tag memory one
//   frame per cycle, then passes ST_LAST and ST_UPDATE, which loads the result
//   register; n is the active frame count (frames_in_use clamped to 1..16). A new
//   reference is taken only once the last one has left ST_UPDATE.
// Reset: all frames empty, recency ranks and fault count zero, frames_in_use 16.
//   The tag memory is not cleared; a tag is used only while its frame is valid.
// Stall: the result register holds while rsp_ready is low; the next request is
//   still taken and scanned, and its update waits until the register is free.
`timescale 1ns / 1ps

module lru_page_replacement (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [lrupr_pkg::PAGE_BITS-1:0] req_page,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_hit,
   output logic [lrupr_pkg::FRAME_W-1:0]   rsp_frame_index,
   output logic                            rsp_evicted_valid,
   output logic [lrupr_pkg::PAGE_BITS-1:0] rsp_evicted_page,
   output logic [lrupr_pkg::FAULT_W-1:0]   rsp_fault_count,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [lrupr_pkg::CFG_W-1:0]     csr_data
);
   import lrupr_pkg::*;

   state_type            state_ff, state_in;
   logic [FRAME_W-1:0]   idx_ff, idx_in;
   logic [PAGE_BITS-1:0] page_ff, page_in;
   logic                 rd_en_ff, rd_en_in;
   logic [FRAME_W-1:0]   rd_idx_ff, rd_idx_in;
   logic [CFG_W-1:0]     cfg_ff;
   logic [FAULT_W-1:0]   fault_ff, fault_in;

   logic                 rsp_valid_ff;
   logic                 rsp_hit_ff;
   logic [FRAME_W-1:0]   rsp_frame_ff;
   logic                 rsp_ev_valid_ff;
   logic [PAGE_BITS-1:0] rsp_ev_page_ff;
   logic [FAULT_W-1:0]   rsp_fault_ff;

   logic [CNT_W-1:0]     n_active;
   logic [FRAME_W-1:0]   last_idx;
   logic                 scan_clear;
   logic                 ram_rd_en;
   logic [PAGE_BITS-1:0] ram_rd_data;
   logic                 upd_fire;
   logic                 miss, fill, evict;
   logic [FRAME_W-1:0]   out_frame;
   logic [RANK_W-1:0]    old_rank;
   logic                 rt_valid;
   logic [RANK_W-1:0]    rt_rank;
   scan_type             scan;
   touch_type            touch;

   // Clamp the configured frame count into 1..FRAME_COUNT.
   always_comb begin
      if (cfg_ff == '0) begin
         n_active = CNT_W'(1);
      end else if (int'(cfg_ff) > FRAME_COUNT) begin
         n_active = CNT_W'(FRAME_COUNT);
      end else begin
         n_active = CNT_W'(cfg_ff);
      end
      last_idx = FRAME_W'(n_active - 1'b1);
   end

   always_comb begin
      miss  = !scan.found;
      fill  = miss && scan.empty_found;
      evict = miss && !scan.empty_found;
      if (scan.found) begin
         out_frame = scan.match_idx;
         old_rank  = scan.match_rank;
      end else if (scan.empty_found) begin
         out_frame = scan.empty_idx;
         old_rank  = RANK_W'(scan.valid_count);
      end else begin
         out_frame = scan.vict_idx;
         old_rank  = scan.vict_rank;
      end
      if (miss && (fault_ff != '1)) begin
         fault_in = fault_ff + 1'b1;
      end else begin
         fault_in = fault_ff;
      end
      upd_fire       = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_ready);
      touch.en       = upd_fire;
      touch.fill     = fill;
      touch.frame    = out_frame;
      touch.old_rank = old_rank;
   end

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      page_in    = page_ff;
      rd_en_in   = 1'b0;
      rd_idx_in  = idx_ff;
      ram_rd_en  = 1'b0;
      scan_clear = 1'b0;
      req_ready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               page_in    = req_page;
               idx_in     = '0;
               scan_clear = 1'b1;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            ram_rd_en = 1'b1;
            rd_en_in  = 1'b1;
            if (idx_ff == last_idx) begin
               state_in = ST_LAST;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_LAST: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (upd_fire) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rd_en_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rd_en_ff <= rd_en_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      page_ff   <= page_in;
      rd_idx_ff <= rd_idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff   <= CFG_RESET;
         fault_ff <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            cfg_ff <= csr_data;
         end
         if (upd_fire) begin
            fault_ff <= fault_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (upd_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (upd_fire) begin
         rsp_hit_ff      <= scan.found;
         rsp_frame_ff    <= out_frame;
         rsp_ev_valid_ff <= evict;
         rsp_ev_page_ff  <= evict ? scan.vict_tag : '0;
         rsp_fault_ff    <= fault_in;
      end
   end

   lrupr_tag_ram #(
      .DEPTH (FRAME_COUNT),
      .WIDTH (PAGE_BITS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (upd_fire && miss),
      .wr_addr (out_frame),
      .wr_data (page_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   lrupr_rank_table u_rank_table (
      .clock    (clock),
      .reset    (reset),
      .n_active (n_active),
      .rd_idx   (rd_idx_ff),
      .touch    (touch),
      .rd_valid (rt_valid),
      .rd_rank  (rt_rank)
   );

   lrupr_scan u_scan (
      .clock       (clock),
      .clear       (scan_clear),
      .data_en     (rd_en_ff),
      .data_idx    (rd_idx_ff),
      .tag         (ram_rd_data),
      .frame_valid (rt_valid),
      .rank        (rt_rank),
      .page        (page_ff),
      .result      (scan)
   );

   assign csr_ready         = (state_ff == ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_index   = rsp_frame_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_page  = rsp_ev_page_ff;
   assign rsp_fault_count   = rsp_fault_ff;

   a_fire_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      upd_fire |=> rsp_valid)
      else $error("update did not load the result register");

   a_fault_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (fault_ff >= $past(fault_ff)))
      else $error("fault count decreased");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> !rsp_evicted_valid)
      else $error("hit transaction reports an eviction");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (idx_ff <= last_idx))
      else $error("scan index beyond active frames");

   a_last_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LAST) |-> rd_en_ff)
      else $error("last scan read not pending");

endmodule

// ===== bench/lru_page_replacement_tb.sv =====
// Self-checking testbench for lru_page_replacement with a queued driver and an LRU predictor.
`timescale 1ns / 1ps

module lru_page_replacement_tb;
   import lrupr_pkg::*;

   localparam int GAP_MAX       = 17;
   localparam int CHOKE_AT      = 360;
   localparam int CHOKE_CYCLES  = 600;
   localparam int STUCK_LIMIT   = 4000;
   localparam int RANDOM_PHASE  = 90;
   localparam int PRINT_CAP     = 100;

   typedef struct packed {
      logic                 hit;
      logic [FRAME_W-1:0]   frame_index;
      logic                 evicted_valid;
      logic [PAGE_BITS-1:0] evicted_page;
      logic [FAULT_W-1:0]   fault_count;
   } lookup_type;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [PAGE_BITS-1:0] req_page  = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_hit;
   logic [FRAME_W-1:0]   rsp_frame_index;
   logic                 rsp_evicted_valid;
   logic [PAGE_BITS-1:0] rsp_evicted_page;
   logic [FAULT_W-1:0]   rsp_fault_count;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CFG_W-1:0]     csr_data  = '0;

   logic [PAGE_BITS-1:0] page_backlog[$];
   lookup_type           predicted_lookups[$];

   logic [PAGE_BITS-1:0] model_tag[FRAME_COUNT]   = '{default: '0};
   bit                   model_valid[FRAME_COUNT] = '{default: 1'b0};
   int                   model_rank[FRAME_COUNT]  = '{default: 0};
   int                   model_faults = 0;
   logic [CFG_W-1:0]     model_frames = CFG_RESET;

   logic [PAGE_BITS-1:0] opening_pages[24] = '{
      16'h0000, 16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA, 16'h0001,
      16'h0002, 16'h00FF, 16'hFF00, 16'h0F0F, 16'hF0F0, 16'h3333, 16'hCCCC, 16'h1000,
      16'h0800, 16'h1357, 16'h0000, 16'h2468, 16'h0000, 16'h1357, 16'hAAAA, 16'hFFFF};
   logic [CFG_W-1:0]     frame_sweep[12] = '{
      5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd8, 5'd12, 5'd15, 5'd16, 5'd17, 5'd31, 5'd0};

   bit tx_burst = 1'b0;
   bit rx_burst = 1'b0;
   int tx_wait = 0;
   int rx_wait = 0;
   int stuck_cycles = 0;
   int refs_sent = 0;
   int results_taken = 0;
   int hits_seen = 0;
   int evictions_seen = 0;
   int cfg_writes = 0;
   int mismatches = 0;

   lru_page_replacement u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_page          (req_page),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hit           (rsp_hit),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_fault_count   (rsp_fault_count),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void promote_frame(input int f, input int old_rank, input int n);
      for (int i = 0; i < n; i++) begin
         if (i != f && model_valid[i] && model_rank[i] < old_rank) model_rank[i]++;
      end
      model_rank[f] = 0;
   endfunction

   function automatic lookup_type lookup_page(input logic [PAGE_BITS-1:0] page);
      lookup_type res;
      int         n;
      int         f;
      int         valid_count;
      int         empty_at;
      int         best;
      bit         found;
      bit         empty_found;
      res         = '0;
      n           = (model_frames == 0) ? 1 :
                    (model_frames > FRAME_COUNT) ? FRAME_COUNT : int'(model_frames);
      f           = 0;
      valid_count = 0;
      empty_at    = 0;
      found       = 1'b0;
      empty_found = 1'b0;
      for (int i = 0; i < n; i++) begin
         if (model_valid[i]) begin
            valid_count++;
            if (!found && model_tag[i] == page) begin
               found = 1'b1;
               f     = i;
            end
         end else if (!empty_found) begin
            empty_found = 1'b1;
            empty_at    = i;
         end
      end
      if (found) begin
         res.hit = 1'b1;
         promote_frame(f, model_rank[f], n);
      end else begin
         if (model_faults < 16'hFFFF) model_faults++;
         if (empty_found) begin
            f              = empty_at;
            model_valid[f] = 1'b1;
            model_tag[f]   = page;
            promote_frame(f, valid_count, n);
         end else begin
            best = 0;
            for (int i = 0; i < n; i++) begin
               if (model_rank[i] > best) begin
                  best = model_rank[i];
                  f    = i;
               end
            end
            res.evicted_valid = 1'b1;
            res.evicted_page  = model_tag[f];
            model_tag[f]      = page;
            promote_frame(f, model_rank[f], n);
         end
      end
      res.frame_index = FRAME_W'(f);
      res.fault_count = FAULT_W'(model_faults);
      return res;
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("%0t: result %0d: %s", $time, results_taken, what);
   endtask

   // drive references; predict each one as its transaction completes
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_page  <= '0;
         tx_wait   <= 0;
      end else begin
         if (req_valid && req_ready) begin
            predicted_lookups.push_back(lookup_page(req_page));
            refs_sent++;
         end
         if (!req_valid || req_ready) begin
            if (tx_wait > 0) begin
               tx_wait   <= tx_wait - 1;
               req_valid <= 1'b0;
            end else if (page_backlog.size() != 0) begin
               req_valid <= 1'b1;
               req_page  <= page_backlog.pop_front();
               tx_wait   <= tx_burst ? 0 : $urandom_range(0, GAP_MAX);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      lookup_type want;
      int         w;
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_wait   <= 0;
      end else if (rsp_valid && rsp_ready) begin
         results_taken++;
         if (predicted_lookups.size() == 0) begin
            report_mismatch("result with no reference outstanding");
         end else begin
            want = predicted_lookups.pop_front();
            if (want.hit) hits_seen++;
            if (want.evicted_valid) evictions_seen++;
            if (rsp_hit !== want.hit)
               report_mismatch($sformatf("hit %b, expected %b", rsp_hit, want.hit));
            if (rsp_frame_index !== want.frame_index)
               report_mismatch($sformatf("frame_index %0d, expected %0d",
                                         rsp_frame_index, want.frame_index));
            if (rsp_evicted_valid !== want.evicted_valid)
               report_mismatch($sformatf("evicted_valid %b, expected %b",
                                         rsp_evicted_valid, want.evicted_valid));
            if (rsp_evicted_page !== want.evicted_page)
               report_mismatch($sformatf("evicted_page %h, expected %h",
                                         rsp_evicted_page, want.evicted_page));
            if (rsp_fault_count !== want.fault_count)
               report_mismatch($sformatf("fault_count %0d, expected %0d",
                                         rsp_fault_count, want.fault_count));
         end
         w = rx_burst ? 0 : $urandom_range(0, GAP_MAX);
         if (results_taken == CHOKE_AT) w = CHOKE_CYCLES;
         rsp_ready <= (w == 0);
         rx_wait   <= w;
      end else if (rx_wait > 0) begin
         rx_wait   <= rx_wait - 1;
         rsp_ready <= (rx_wait == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", stuck_cycles);
         $display("*** FAILED ***");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   task automatic settle();
      do @(negedge clock);
      while (page_backlog.size() != 0 || req_valid || predicted_lookups.size() != 0);
   endtask

   task automatic set_frames(input logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      model_frames = value;
      cfg_writes++;
   endtask

   task automatic queue_opening(input int first, input int last);
      @(negedge clock);
      for (int k = first; k <= last; k++) page_backlog.push_back(opening_pages[k]);
      settle();
   endtask

   task automatic queue_random_refs(input int count);
      logic [PAGE_BITS-1:0] pool[24];
      int                   span;
      span = 1;
      foreach (pool[i]) pool[i] = PAGE_BITS'($urandom);
      @(negedge clock);
      for (int k = 0; k < count; k++) begin
         if (k % 16 == 0) span = $urandom_range(1, 24);
         if ($urandom_range(0, 9) == 0) page_backlog.push_back(PAGE_BITS'($urandom));
         else page_backlog.push_back(pool[$urandom_range(0, span - 1)]);
      end
      settle();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // fill all sixteen frames, hit, then evict the oldest
      queue_opening(0, 17);
      // zero acts as one frame; upper frames keep their pages
      set_frames(5'd0);
      queue_opening(18, 19);
      // two frames tied at the youngest rank; lowest one goes
      set_frames(5'd2);
      queue_opening(20, 21);
      // oversize count clamps to sixteen; the hidden frames come back
      set_frames(5'd31);
      queue_opening(22, 23);

      foreach (frame_sweep[p]) begin
         tx_burst = (p % 3 == 1);
         rx_burst = (p % 4 == 2);
         set_frames(frame_sweep[p]);
         queue_random_refs(RANDOM_PHASE);
      end

      tx_burst = 1'b0;
      rx_burst = 1'b0;
      set_frames(5'd7);
      queue_random_refs(48);

      repeat (40) @(posedge clock);
      $display("Covered %0d page references (%0d results) over %0d frame-count writes,",
               refs_sent, results_taken, cfg_writes);
      $display("with %0d hits, %0d evictions, final fault count %0d, %0d mismatches.",
               hits_seen, evictions_seen, model_faults, mismatches);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
